/* rtl/core/spgs_pkg.sv */
// ----------------------------------------------------------------------------
// spgs_pkg - shared types and constants for the skin pixel steering unit
// Register indexes, command codes, skin rule limits and window defaults.
// ----------------------------------------------------------------------------
package spgs_pkg;

    localparam int unsigned IMG_W    = 10;
    localparam int unsigned CTRL_W   = 12;
    localparam int unsigned SIDE_W   = 15;
    localparam int unsigned PERSIST_W = 8;
    localparam int unsigned ARM_W    = 5;
    localparam int unsigned DISARM_W = 6;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 48;

    localparam int unsigned DEF_CTRL_ORIGIN = 25;
    localparam int unsigned DEF_CTRL_SIZE   = 50;
    localparam int unsigned DEF_SIDE_TOP    = 100;
    localparam int unsigned DEF_LEFT_START  = 50;
    localparam int unsigned DEF_RIGHT_START = 450;
    localparam int unsigned DEF_SIDE_SIZE   = 150;

    localparam logic [CTRL_W-1:0]    RST_PRESENCE = 12'd350;
    localparam logic [SIDE_W-1:0]    RST_REGION   = 15'd5000;
    localparam logic [PERSIST_W-1:0] RST_PERSIST  = 8'd5;
    localparam logic [ARM_W-1:0]     RST_ARM      = 5'd20;
    localparam logic [DISARM_W-1:0]  RST_DISARM   = 6'd35;

    localparam logic [7:0] DAY_R_MIN    = 8'd95;
    localparam logic [7:0] DAY_G_MIN    = 8'd40;
    localparam logic [7:0] DAY_B_MIN    = 8'd20;
    localparam logic [7:0] SPREAD_MIN   = 8'd15;
    localparam logic [7:0] BRIGHT_R_MIN = 8'd220;
    localparam logic [7:0] BRIGHT_G_MIN = 8'd210;
    localparam logic [7:0] BRIGHT_B_MIN = 8'd170;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PRESENCE = 3'd0,
        REG_REGION   = 3'd1,
        REG_PERSIST  = 3'd2,
        REG_ARM      = 3'd3,
        REG_DISARM   = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_GO    = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_RIGHT = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

endpackage

/* rtl/core/skin_pixel_gesture_steering_unit.sv */
// ----------------------------------------------------------------------------
// skin_pixel_gesture_steering_unit - skin pixel counter and steering decision
// Classes each pixel by the RGB skin rule, counts skin in three windows and
// issues one steering word at the end of every frame.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while s_tready is high. A pixel is first held
// in the classify register, where the skin rule and window hits are resolved,
// and is then counted; the word marked with s_tlast ends the frame and yields
// one registered result word. No other pixel yields a result. While the
// result word is not taken, pixels keep flowing; only the next word marked with
// s_tlast is held in the classify register, and s_tready stays low until the
// result word is taken. Configuration writes take effect at once and are
// meant to be made between frames.
module skin_pixel_gesture_steering_unit #(
    parameter int unsigned CTRL_ORIGIN = spgs_pkg::DEF_CTRL_ORIGIN,
    parameter int unsigned CTRL_SIZE   = spgs_pkg::DEF_CTRL_SIZE,
    parameter int unsigned SIDE_TOP    = spgs_pkg::DEF_SIDE_TOP,
    parameter int unsigned LEFT_START  = spgs_pkg::DEF_LEFT_START,
    parameter int unsigned RIGHT_START = spgs_pkg::DEF_RIGHT_START,
    parameter int unsigned SIDE_SIZE   = spgs_pkg::DEF_SIDE_SIZE
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [spgs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [spgs_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // red, green, blue, pixel_row, pixel_column, zero pad
    input  logic [spgs_pkg::S_DATA_W-1:0]      s_tdata,
    // frame_end
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // command, armed_flag, control_skin_count, left_skin_count,
    // right_skin_count, zero pad
    output logic [spgs_pkg::M_DATA_W-1:0]      m_tdata
);
    import spgs_pkg::*;

    localparam int unsigned BW = IMG_W + 1;
    localparam logic [BW-1:0] CTRL_LO  = BW'(CTRL_ORIGIN);
    localparam logic [BW-1:0] CTRL_HI  = BW'(CTRL_ORIGIN + CTRL_SIZE);
    localparam logic [BW-1:0] SIDE_LO  = BW'(SIDE_TOP);
    localparam logic [BW-1:0] SIDE_HI  = BW'(SIDE_TOP + SIDE_SIZE);
    localparam logic [BW-1:0] LEFT_LO  = BW'(LEFT_START);
    localparam logic [BW-1:0] LEFT_HI  = BW'(LEFT_START + SIDE_SIZE);
    localparam logic [BW-1:0] RIGHT_LO = BW'(RIGHT_START);
    localparam logic [BW-1:0] RIGHT_HI = BW'(RIGHT_START + SIDE_SIZE);

    // configuration
    logic [CTRL_W-1:0]    presence_reg;
    logic [SIDE_W-1:0]    region_reg;
    logic [PERSIST_W-1:0] persist_reg;
    logic [ARM_W-1:0]     arm_lim_reg;
    logic [DISARM_W-1:0]  disarm_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presence_reg   <= RST_PRESENCE;
            region_reg     <= RST_REGION;
            persist_reg    <= RST_PERSIST;
            arm_lim_reg    <= RST_ARM;
            disarm_lim_reg <= RST_DISARM;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PRESENCE: presence_reg   <= cfg_wr_data[CTRL_W-1:0];
                REG_REGION:   region_reg     <= cfg_wr_data[SIDE_W-1:0];
                REG_PERSIST:  persist_reg    <= cfg_wr_data[PERSIST_W-1:0];
                REG_ARM:      arm_lim_reg    <= cfg_wr_data[ARM_W-1:0];
                REG_DISARM:   disarm_lim_reg <= cfg_wr_data[DISARM_W-1:0];
                default: ;
            endcase
        end
    end

    // classify
    logic [7:0]    red, green, blue;
    logic [BW-1:0] row_x, col_x;
    logic [7:0]    mx, mn, rg_diff;
    logic          day_skin, bright_skin, skin;
    logic          row_ctrl, col_ctrl, row_side, col_left, col_right;

    always_comb begin
        red   = s_tdata[7:0];
        green = s_tdata[15:8];
        blue  = s_tdata[23:16];
        row_x = {1'b0, s_tdata[33:24]};
        col_x = {1'b0, s_tdata[43:34]};

        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;
        rg_diff = (red > green) ? (red - green) : (green - red);

        day_skin = (red > DAY_R_MIN) && (green > DAY_G_MIN) && (blue > DAY_B_MIN)
                && ((mx - mn) > SPREAD_MIN) && (rg_diff > SPREAD_MIN)
                && (red > green) && (red > blue);
        bright_skin = (red > BRIGHT_R_MIN) && (green > BRIGHT_G_MIN)
                   && (blue > BRIGHT_B_MIN) && (rg_diff <= SPREAD_MIN)
                   && (red > blue) && (green > blue);
        skin = day_skin || bright_skin;

        row_ctrl  = (row_x >= CTRL_LO) && (row_x < CTRL_HI);
        col_ctrl  = (col_x >= CTRL_LO) && (col_x < CTRL_HI);
        row_side  = (row_x >= SIDE_LO) && (row_x < SIDE_HI);
        col_left  = (col_x >= LEFT_LO) && (col_x < LEFT_HI);
        col_right = (col_x >= RIGHT_LO) && (col_x < RIGHT_HI);
    end

    logic a_vld_reg, a_vld_next;
    logic a_ctrl_reg, a_left_reg, a_right_reg, a_last_reg;
    logic advance;
    logic m_vld_reg, m_vld_next;

    assign advance  = a_vld_reg && (!a_last_reg || !m_vld_reg || m_tready);
    assign s_tready = !a_vld_reg || advance;
    assign a_vld_next = (s_tvalid && s_tready) || (a_vld_reg && !advance);
    assign m_vld_next = (m_vld_reg && !m_tready) || (advance && a_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_ctrl_reg  <= skin && row_ctrl && col_ctrl;
            a_left_reg  <= skin && row_side && col_left;
            a_right_reg <= skin && row_side && col_right;
            a_last_reg  <= s_tlast;
        end
    end

    // count and decide
    logic [CTRL_W-1:0]    ctrl_acc_reg, ctrl_cnt;
    logic [SIDE_W-1:0]    left_acc_reg, left_cnt, right_acc_reg, right_cnt;
    logic [ARM_W-1:0]     arm_reg, arm_next, arm_a;
    logic [DISARM_W-1:0]  dis_reg, dis_next, dis_a;
    logic                 armed_reg, armed_next;
    logic [PERSIST_W-1:0] lp_reg, lp_next, rp_reg, rp_next;
    logic                 gesture, steer, lon, ron;
    cmd_t                 cmd;

    always_comb begin
        ctrl_cnt  = (a_ctrl_reg && ctrl_acc_reg != '1) ? ctrl_acc_reg + 1'b1 : ctrl_acc_reg;
        left_cnt  = (a_left_reg && left_acc_reg != '1) ? left_acc_reg + 1'b1 : left_acc_reg;
        right_cnt = (a_right_reg && right_acc_reg != '1) ? right_acc_reg + 1'b1
                                                         : right_acc_reg;

        gesture = ctrl_cnt > presence_reg;
        arm_a = arm_reg;
        dis_a = dis_reg;
        if (gesture && !armed_reg) begin
            arm_a = (arm_reg != '1) ? arm_reg + 1'b1 : arm_reg;
            dis_a = '0;
        end

        steer      = arm_a > arm_lim_reg;
        armed_next = armed_reg || steer;
        lp_next    = lp_reg;
        rp_next    = rp_reg;
        cmd        = CMD_NONE;
        if (steer) begin
            if (left_cnt > region_reg) begin
                lp_next = (lp_reg != '1) ? lp_reg + 1'b1 : lp_reg;
            end else begin
                lp_next = '0;
            end
            if (right_cnt > region_reg) begin
                rp_next = (rp_reg != '1) ? rp_reg + 1'b1 : rp_reg;
            end else begin
                rp_next = '0;
            end
        end
        lon = lp_next > persist_reg;
        ron = rp_next > persist_reg;
        if (steer) begin
            priority if (lon && ron) cmd = CMD_GO;
            else if (lon)            cmd = CMD_LEFT;
            else if (ron)            cmd = CMD_RIGHT;
            else                     cmd = CMD_STOP;
        end

        dis_next = dis_a;
        if (gesture && armed_next) begin
            dis_next = (dis_a != '1) ? dis_a + 1'b1 : dis_a;
        end
        arm_next = arm_a;
        if (dis_next > disarm_lim_reg) begin
            armed_next = 1'b0;
            arm_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_acc_reg  <= '0;
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
            arm_reg       <= '0;
            dis_reg       <= '0;
            armed_reg     <= 1'b0;
            lp_reg        <= '0;
            rp_reg        <= '0;
        end else if (advance) begin
            if (a_last_reg) begin
                ctrl_acc_reg  <= '0;
                left_acc_reg  <= '0;
                right_acc_reg <= '0;
                arm_reg       <= arm_next;
                dis_reg       <= dis_next;
                armed_reg     <= armed_next;
                lp_reg        <= lp_next;
                rp_reg        <= rp_next;
            end else begin
                ctrl_acc_reg  <= ctrl_cnt;
                left_acc_reg  <= left_cnt;
                right_acc_reg <= right_cnt;
            end
        end
    end

    logic [M_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (advance && a_last_reg) begin
            m_data_reg <= {2'b00, right_cnt, left_cnt, ctrl_cnt, armed_next, cmd};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* verif/skin_pixel_gesture_steering_checker.sv */
// ----------------------------------------------------------------------------
// skin_pixel_gesture_steering_checker - steering word predictor and scoreboard
// Watches the register port and both streams, keeps its own copy of the skin
// counters and the arm, disarm and persistence state, and compares every
// steering word with the oldest predicted one.
// ----------------------------------------------------------------------------
module skin_pixel_gesture_steering_checker #(
    parameter int unsigned CTRL_ORIGIN = spgs_pkg::DEF_CTRL_ORIGIN,
    parameter int unsigned CTRL_SIZE   = spgs_pkg::DEF_CTRL_SIZE,
    parameter int unsigned SIDE_TOP    = spgs_pkg::DEF_SIDE_TOP,
    parameter int unsigned LEFT_START  = spgs_pkg::DEF_LEFT_START,
    parameter int unsigned RIGHT_START = spgs_pkg::DEF_RIGHT_START,
    parameter int unsigned SIDE_SIZE   = spgs_pkg::DEF_SIDE_SIZE
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [spgs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [spgs_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [spgs_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tlast,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [spgs_pkg::M_DATA_W-1:0]      m_tdata,
    output int                                 mismatch_count,
    output int                                 words_pending,
    output int                                 words_checked
);
    import spgs_pkg::*;

    typedef struct packed {
        cmd_t              command;
        logic              armed;
        logic [CTRL_W-1:0] ctrl_count;
        logic [SIDE_W-1:0] left_count;
        logic [SIDE_W-1:0] right_count;
    } steer_word_t;

    logic [CTRL_W-1:0]    presence_lim;
    logic [SIDE_W-1:0]    region_lim;
    logic [PERSIST_W-1:0] persist_lim;
    logic [ARM_W-1:0]     arm_lim;
    logic [DISARM_W-1:0]  disarm_lim;

    logic [CTRL_W-1:0]    ctrl_acc;
    logic [SIDE_W-1:0]    left_acc;
    logic [SIDE_W-1:0]    right_acc;
    logic [ARM_W-1:0]     arm_cnt;
    logic [DISARM_W-1:0]  disarm_cnt;
    logic                 steering_armed;
    logic [PERSIST_W-1:0] left_run;
    logic [PERSIST_W-1:0] right_run;

    steer_word_t steer_words_due[$];

    function automatic logic is_skin_tone(input logic [7:0] r, g, b);
        logic [7:0] hi, lo, rg_gap;
        logic daylight, bright;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        rg_gap = (r > g) ? r - g : g - r;
        daylight = r > DAY_R_MIN && g > DAY_G_MIN && b > DAY_B_MIN &&
                   (hi - lo) > SPREAD_MIN && rg_gap > SPREAD_MIN && r > g && r > b;
        bright = r > BRIGHT_R_MIN && g > BRIGHT_G_MIN && b > BRIGHT_B_MIN &&
                 rg_gap <= SPREAD_MIN && r > b && g > b;
        return daylight || bright;
    endfunction

    function automatic logic in_span(input int unsigned v, start, size);
        return v >= start && v < start + size;
    endfunction

    function automatic void reset_model();
        presence_lim   = RST_PRESENCE;
        region_lim     = RST_REGION;
        persist_lim    = RST_PERSIST;
        arm_lim        = RST_ARM;
        disarm_lim     = RST_DISARM;
        ctrl_acc       = '0;
        left_acc       = '0;
        right_acc      = '0;
        arm_cnt        = '0;
        disarm_cnt     = '0;
        steering_armed = 1'b0;
        left_run       = '0;
        right_run      = '0;
        steer_words_due.delete();
    endfunction

    function automatic void write_limit(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_PRESENCE: presence_lim = value[CTRL_W-1:0];
            REG_REGION:   region_lim   = value[SIDE_W-1:0];
            REG_PERSIST:  persist_lim  = value[PERSIST_W-1:0];
            REG_ARM:      arm_lim      = value[ARM_W-1:0];
            REG_DISARM:   disarm_lim   = value[DISARM_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void count_pixel(input logic [S_DATA_W-1:0] word, input logic frame_end);
        logic [IMG_W-1:0] row, col;
        logic gesture, left_on, right_on;
        steer_word_t res;
        row = word[33:24];
        col = word[43:34];
        if (is_skin_tone(word[7:0], word[15:8], word[23:16])) begin
            if (in_span(32'(row), CTRL_ORIGIN, CTRL_SIZE)
                    && in_span(32'(col), CTRL_ORIGIN, CTRL_SIZE) && ctrl_acc != '1)
                ctrl_acc = ctrl_acc + 1'b1;
            if (in_span(32'(row), SIDE_TOP, SIDE_SIZE)) begin
                if (in_span(32'(col), LEFT_START, SIDE_SIZE) && left_acc != '1)
                    left_acc = left_acc + 1'b1;
                if (in_span(32'(col), RIGHT_START, SIDE_SIZE) && right_acc != '1)
                    right_acc = right_acc + 1'b1;
            end
        end
        if (frame_end) begin
            res.command = CMD_NONE;
            gesture = ctrl_acc > presence_lim;
            if (gesture && !steering_armed) begin
                if (arm_cnt != '1) arm_cnt = arm_cnt + 1'b1;
                disarm_cnt = '0;
            end
            if (arm_cnt > arm_lim) begin
                steering_armed = 1'b1;
                if (left_acc > region_lim) begin
                    if (left_run != '1) left_run = left_run + 1'b1;
                end else begin
                    left_run = '0;
                end
                if (right_acc > region_lim) begin
                    if (right_run != '1) right_run = right_run + 1'b1;
                end else begin
                    right_run = '0;
                end
                left_on  = left_run > persist_lim;
                right_on = right_run > persist_lim;
                if (left_on && right_on) res.command = CMD_GO;
                else if (left_on)        res.command = CMD_LEFT;
                else if (right_on)       res.command = CMD_RIGHT;
                else                     res.command = CMD_STOP;
            end
            if (gesture && steering_armed && disarm_cnt != '1)
                disarm_cnt = disarm_cnt + 1'b1;
            if (disarm_cnt > disarm_lim) begin
                steering_armed = 1'b0;
                arm_cnt = '0;
            end
            res.armed       = steering_armed;
            res.ctrl_count  = ctrl_acc;
            res.left_count  = left_acc;
            res.right_count = right_acc;
            steer_words_due.push_back(res);
            ctrl_acc  = '0;
            left_acc  = '0;
            right_acc = '0;
        end
    endfunction

    function automatic logic field_ok(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    initial reset_model();

    always @(posedge aclk) begin
        steer_word_t got, want;
        logic ok;
        if (!aresetn) begin
            reset_model();
        end else begin
            if (cfg_wr_en) write_limit(cfg_reg_t'(cfg_addr), cfg_wr_data);
            if (s_tvalid && s_tready) count_pixel(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.command     = cmd_t'(m_tdata[2:0]);
                got.armed       = m_tdata[3];
                got.ctrl_count  = m_tdata[15:4];
                got.left_count  = m_tdata[30:16];
                got.right_count = m_tdata[45:31];
                if (steer_words_due.size() == 0) begin
                    $display("%0t: unexpected steering word expected none actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = steer_words_due.pop_front();
                    words_checked++;
                    ok = field_ok("command", 32'(want.command), 32'(got.command))
                       & field_ok("armed_flag", 32'(want.armed), 32'(got.armed))
                       & field_ok("control_skin_count", 32'(want.ctrl_count),
                                  32'(got.ctrl_count))
                       & field_ok("left_skin_count", 32'(want.left_count),
                                  32'(got.left_count))
                       & field_ok("right_skin_count", 32'(want.right_count),
                                  32'(got.right_count));
                    if (!ok) mismatch_count++;
                end
            end
        end
        words_pending = steer_words_due.size();
    end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench - regression for skin_pixel_gesture_steering_unit
// Drives pixel frames through the unit under three idle patterns and walks
// the steering registers through small values, saturation runs and both
// extremes; the checker predicts and compares every steering word.
// ----------------------------------------------------------------------------
module testbench;
    import spgs_pkg::*;

    typedef enum {TONE_DAY, TONE_BRIGHT, TONE_ANY} tone_t;
    typedef enum {SPOT_CTRL, SPOT_LEFT, SPOT_RIGHT, SPOT_ANY} spot_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int mismatch_count;
    int words_pending;
    int words_checked;
    int send_idle_pct = 22;
    int recv_idle_pct = 72;
    int pixels_sent = 0;
    int settings_loaded = 0;

    skin_pixel_gesture_steering_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    skin_pixel_gesture_steering_checker u_steering_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("skin_pixel_gesture_steering_unit regression: fail");
        $finish;
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic push_pixel(input logic [7:0] r, g, b, input logic [IMG_W-1:0] row, col,
                              input logic frame_end);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, col, row, b, g, r};
        s_tlast  <= frame_end;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (words_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic void pick_tone(input tone_t tone, output logic [7:0] r, g, b);
        int unsigned lo_g, hi_g;
        case (tone)
            TONE_DAY: begin
                r = 8'($urandom_range(255, 96));
                g = 8'($urandom_range(r - 16, 41));
                b = 8'($urandom_range(r - 1, 21));
            end
            TONE_BRIGHT: begin
                r = 8'($urandom_range(255, 221));
                lo_g = (r - 15 > 211) ? r - 15 : 211;
                hi_g = (r + 15 < 255) ? r + 15 : 255;
                g = 8'($urandom_range(hi_g, lo_g));
                b = 8'($urandom_range(((r < g) ? r : g) - 1, 171));
            end
            default: begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
        endcase
    endfunction

    task automatic send_pixel(input spot_t spot, input tone_t tone, input logic frame_end);
        logic [7:0] r, g, b;
        logic [IMG_W-1:0] row, col;
        pick_tone(tone, r, g, b);
        case (spot)
            SPOT_CTRL: begin
                row = IMG_W'($urandom_range(DEF_CTRL_ORIGIN + DEF_CTRL_SIZE - 1,
                                            DEF_CTRL_ORIGIN));
                col = IMG_W'($urandom_range(DEF_CTRL_ORIGIN + DEF_CTRL_SIZE - 1,
                                            DEF_CTRL_ORIGIN));
            end
            SPOT_LEFT: begin
                row = IMG_W'($urandom_range(DEF_SIDE_TOP + DEF_SIDE_SIZE - 1, DEF_SIDE_TOP));
                col = IMG_W'($urandom_range(DEF_LEFT_START + DEF_SIDE_SIZE - 1,
                                            DEF_LEFT_START));
            end
            SPOT_RIGHT: begin
                row = IMG_W'($urandom_range(DEF_SIDE_TOP + DEF_SIDE_SIZE - 1, DEF_SIDE_TOP));
                col = IMG_W'($urandom_range(DEF_RIGHT_START + DEF_SIDE_SIZE - 1,
                                            DEF_RIGHT_START));
            end
            default: begin
                row = IMG_W'($urandom);
                col = IMG_W'($urandom);
            end
        endcase
        push_pixel(r, g, b, row, col, frame_end);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value,
                             input int unsigned width);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= CFG_DATA_W'(value | ($urandom << width));
    endtask

    task automatic load_settings(input int unsigned presence, region, persist, arm, disarm);
        wait_for_results();
        write_reg(REG_PRESENCE, presence, CTRL_W);
        write_reg(REG_REGION, region, SIDE_W);
        write_reg(REG_PERSIST, persist, PERSIST_W);
        write_reg(REG_ARM, arm, ARM_W);
        write_reg(REG_DISARM, disarm, DISARM_W);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_loaded++;
    endtask

    task automatic run_frames(input int n_frames);
        int unsigned len, ctrl_w, left_w, right_w, pick;
        spot_t spot;
        tone_t tone;
        for (int f = 0; f < n_frames; f++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
            ctrl_w  = $urandom_range(50);
            left_w  = $urandom_range(25);
            right_w = $urandom_range(25);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < ctrl_w)                          spot = SPOT_CTRL;
                else if (pick < ctrl_w + left_w)            spot = SPOT_LEFT;
                else if (pick < ctrl_w + left_w + right_w)  spot = SPOT_RIGHT;
                else                                        spot = SPOT_ANY;
                pick = $urandom_range(99);
                if (pick < 60)      tone = TONE_DAY;
                else if (pick < 72) tone = TONE_BRIGHT;
                else                tone = TONE_ANY;
                send_pixel(spot, tone, i == len - 1);
            end
            // hold the sender until the steering words drain
            if ($urandom_range(9) == 0) wait_for_results();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset limits: window edges and skin rule boundaries
        push_pixel(200, 100, 80, 25, 25, 1'b0);
        push_pixel(200, 100, 80, 74, 74, 1'b0);
        push_pixel(200, 100, 80, 24, 50, 1'b0);
        push_pixel(200, 100, 80, 75, 50, 1'b0);
        push_pixel(200, 100, 80, 50, 24, 1'b0);
        push_pixel(200, 100, 80, 50, 75, 1'b0);
        push_pixel(96, 41, 21, 50, 50, 1'b0);
        push_pixel(95, 41, 21, 50, 50, 1'b0);
        push_pixel(96, 80, 21, 50, 50, 1'b0);
        push_pixel(96, 81, 21, 50, 50, 1'b0);
        push_pixel(96, 41, 20, 50, 50, 1'b0);
        push_pixel(96, 40, 21, 50, 50, 1'b0);
        push_pixel(221, 211, 171, 50, 50, 1'b0);
        push_pixel(220, 211, 171, 50, 50, 1'b0);
        push_pixel(255, 240, 171, 50, 50, 1'b0);
        push_pixel(221, 210, 171, 50, 50, 1'b0);
        push_pixel(255, 255, 255, 50, 50, 1'b0);
        push_pixel(0, 0, 0, 50, 50, 1'b0);
        push_pixel(200, 100, 80, 100, 50, 1'b0);
        push_pixel(200, 100, 80, 249, 199, 1'b0);
        push_pixel(200, 100, 80, 100, 450, 1'b0);
        push_pixel(200, 100, 80, 249, 599, 1'b0);
        push_pixel(200, 100, 80, 250, 599, 1'b0);
        push_pixel(200, 100, 80, 99, 450, 1'b0);
        push_pixel(255, 255, 254, 1023, 1023, 1'b1);

        load_settings(0, 0, 0, 0, 0);
        run_frames(15);
        load_settings(1, 2, 1, 2, 3);
        run_frames(15);

        wait_for_results();
        send_idle_pct = 72;
        recv_idle_pct = 22;
        load_settings(2, 1, 3, 1, 6);
        run_frames(15);

        // drive the arm counter into saturation; it can never pass 31
        load_settings(0, 32767, 255, 31, 0);
        repeat (36) send_pixel(SPOT_CTRL, TONE_DAY, 1'b1);

        // arm at once, then saturate the disarm counter while armed
        load_settings(0, 0, 0, 0, 63);
        for (int f = 0; f < 70; f++) begin
            send_pixel(SPOT_CTRL, TONE_DAY, 1'b0);
            send_pixel(SPOT_LEFT, TONE_BRIGHT, 1'b0);
            send_pixel(f % 2 ? SPOT_RIGHT : SPOT_ANY, TONE_DAY, 1'b1);
        end

        wait_for_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // no gestures: stay armed and saturate the left persistence
        load_settings(4095, 0, 254, 0, 63);
        for (int f = 0; f < 258; f++) begin
            send_pixel(SPOT_LEFT, TONE_DAY, f % 3 != 0);
            if (f % 3 == 0) send_pixel(SPOT_RIGHT, TONE_DAY, 1'b1);
        end

        repeat (3) begin
            load_settings($urandom_range(4), $urandom_range(3), $urandom_range(3),
                          $urandom_range(3), $urandom_range(5));
            run_frames(8);
        end

        wait_for_results();
        $display("covered %0d pixel words under %0d register settings and three idle patterns",
                 pixels_sent, settings_loaded);
        $display("checked %0d steering words, %0d failing", words_checked, mismatch_count);
        if (mismatch_count == 0 && words_pending == 0) begin
            $display("skin_pixel_gesture_steering_unit regression: pass");
        end else begin
            $display("skin_pixel_gesture_steering_unit regression: fail");
        end
        $finish;
    end

endmodule
